### rtl/ise_pkg.sv
package ise_pkg;

   localparam int MAX_COUNT = 32;
   localparam int VALUE_W   = 32;
   localparam int CNT_W     = $clog2(MAX_COUNT + 1);

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctl_type;

endpackage

### rtl/ise_cell.sv
module ise_cell (
   input  logic                                clock,
   input  ise_pkg::cell_ctl_type               ctl,
   input  logic                                occupied,
   input  logic signed [ise_pkg::VALUE_W-1:0]  new_value,
   input  logic signed [ise_pkg::VALUE_W-1:0]  left_value,
   input  logic                                left_greater,
   input  logic signed [ise_pkg::VALUE_W-1:0]  right_value,
   output logic signed [ise_pkg::VALUE_W-1:0]  value,
   output logic                                greater
);

   logic signed [ise_pkg::VALUE_W-1:0] value_ff;
   logic signed [ise_pkg::VALUE_W-1:0] value_in;

   // An empty cell counts as greater, so the new word lands in the first
   // empty slot when nothing held is greater than it. Equal words stay put.
   assign greater = !occupied || (value_ff > new_value);
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.insert && greater) begin
         value_in = left_greater ? left_value : new_value;
      end else if (ctl.drain) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### rtl/insertion_sort_engine_core.sv
// Insertion sort engine. Words of a run are taken one per clock while busy is
// low: each cell of a row of MAX_COUNT cells compares its word with the new
// one and either keeps it, takes its left neighbor's word or takes the new
// word, so an insertion finishes in the cycle it is accepted. The word with
// final_req set closes the run; from the next cycle on the row shifts toward
// its head and presents one sorted word per cycle on rsp_strobe until every
// word held (1 to MAX_COUNT) is out, with busy high throughout. The next run
// may start in the cycle after its last result. Results are not held: the
// receiver must take each word in the cycle it is strobed. Words beyond
// MAX_COUNT are discarded and rsp_dropped is set on every result of that run.
module insertion_sort_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ise_pkg::VALUE_W-1:0]  req_value,
   input  logic                                req_final_req,
   output logic                                rsp_strobe,
   output logic signed [ise_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic                                rsp_end_of_run,
   output logic                                rsp_dropped
);

   localparam logic [ise_pkg::CNT_W-1:0] FULL_COUNT = ise_pkg::CNT_W'(ise_pkg::MAX_COUNT);
   localparam logic [ise_pkg::CNT_W-1:0] ONE_COUNT  = ise_pkg::CNT_W'(1);

   ise_pkg::state_type     state_ff, state_in;
   logic [ise_pkg::CNT_W-1:0] count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   ise_pkg::cell_ctl_type  ctl;
   logic                   accept;
   logic                   full;

   logic signed [ise_pkg::VALUE_W-1:0] cell_value [ise_pkg::MAX_COUNT];
   logic                               cell_greater [ise_pkg::MAX_COUNT];

   assign full   = (count_ff == FULL_COUNT);
   assign accept = start && (state_ff == ise_pkg::ST_LOAD);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      ctl         = '0;
      busy        = 1'b0;
      rsp_strobe  = 1'b0;
      case (state_ff)
         ise_pkg::ST_LOAD: begin
            if (accept) begin
               if (!full) begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + ONE_COUNT;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_final_req) begin
                  state_in = ise_pkg::ST_DRAIN;
               end
            end
         end
         ise_pkg::ST_DRAIN: begin
            busy       = 1'b1;
            rsp_strobe = 1'b1;
            ctl.drain  = 1'b1;
            count_in   = count_ff - ONE_COUNT;
            if (count_ff == ONE_COUNT) begin
               state_in    = ise_pkg::ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ise_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ise_pkg::ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   for (genvar i = 0; i < ise_pkg::MAX_COUNT; i++) begin : g_cell
      logic signed [ise_pkg::VALUE_W-1:0] left_value;
      logic                               left_greater;
      logic signed [ise_pkg::VALUE_W-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_value   = req_value;
         assign left_greater = 1'b0;
      end else begin : g_body
         assign left_value   = cell_value[i-1];
         assign left_greater = cell_greater[i-1];
      end

      // The tail cell becomes empty on a shift, so its new word is unused.
      if (i == ise_pkg::MAX_COUNT - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      ise_cell u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .occupied     (ise_pkg::CNT_W'(i) < count_ff),
         .new_value    (req_value),
         .left_value   (left_value),
         .left_greater (left_greater),
         .right_value  (right_value),
         .value        (cell_value[i]),
         .greater      (cell_greater[i])
      );
   end

   assign rsp_sorted_value = cell_value[0];
   assign rsp_end_of_run   = rsp_strobe && (count_ff == ONE_COUNT);
   assign rsp_dropped      = overflow_ff;

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count exceeds capacity");

   a_strobe_nonempty : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (count_ff != '0))
      else $error("result strobed from an empty store");

   a_drain_continues : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_end_of_run) |=> rsp_strobe)
      else $error("run output stopped before its last word");

   a_run_closes : assert property (@(posedge clock) disable iff (reset)
      rsp_end_of_run |=> (!busy && count_ff == '0 && !overflow_ff))
      else $error("store not emptied after end of run");

endmodule
